FILE: design/base64_stream_decoder_assert.svh
// Assertion macros used by the top level of the base64 stream decoder.
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// Check that a condition implies another condition in the same cycle.
`define B64D_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("base64 decoder check failed");

// Check that a condition implies another condition in the next cycle.
`define B64D_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("base64 decoder check failed");

`endif

FILE: design/b64d_pkg.sv
// Types, constants and helper functions of the base64 stream decoder.
package b64d_pkg;

    localparam logic [7:0] ALPHA_LOW  = 8'd43;
    localparam logic [7:0] ALPHA_HIGH = 8'd122;
    localparam logic [7:0] PAD_CHAR   = 8'd61;
    localparam logic [7:0] TOP2_MASK  = 8'hc0;

    // One decode job: up to three bytes, byte 0 in the low bits.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
    } job_t;

    // Map a character to {valid, sextet}.
    function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c < ALPHA_LOW || c > ALPHA_HIGH || c == PAD_CHAR) begin
            r = 7'd0;
        end else if (c >= 8'h41 && c <= 8'h5a) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2b) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'h2f) begin
            r = {1'b1, 6'd63};
        end
        return r;
    endfunction

    // Pack four sextets into three bytes.
    function automatic logic [2:0][7:0] decode_group(input logic [5:0] s0,
                                                     input logic [5:0] s1,
                                                     input logic [5:0] s2,
                                                     input logic [5:0] s3);
        logic [2:0][7:0] b;
        b[0] = {s0, s1[5:4]};
        b[1] = {s1[3:0], s2[5:2]};
        b[2] = ({s2[1:0], 6'd0} & TOP2_MASK) | {2'b00, s3};
        return b;
    endfunction

endpackage

FILE: design/base64_stream_decoder.sv
// Top level of the streaming base64 decoder.

// Streaming base64 decoder. Each input beat carries one character of
// encoded text in s_tdata; characters outside the standard alphabet
// ('+' and '/' for 62 and 63), '=' included, are skipped. Four sextets
// give three output bytes; s_tlast on an input beat flushes a partial
// group of n sextets as n-1 bytes and clears the group. Each output beat
// carries one byte, with m_tlast on the last byte caused by one input
// character. Rate: one input beat per cycle while s_tready is high, one
// output byte per cycle while m_tready is high and a job is at hand; the
// front end classifies a character and posts its decode job in the cycle
// it is accepted; the back end takes the job from the queue into its job
// register once that is free and shows its first byte from there. A
// queue of QUEUE_DEPTH jobs decouples the two sides; s_tready drops only
// once it is full, i.e. output stalls have backed up QUEUE_DEPTH jobs.
module base64_stream_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic       s_tlast,   // is_final
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // run_last
);
    import b64d_pkg::*;

`include "base64_stream_decoder_assert.svh"

    logic       accept;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;
    job_t       push_job;
    job_t       pop_job;
    logic [6:0] in_sx;

    // Accept whenever the job queue has room for a possible job.
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign in_sx    = char_to_sextet(s_tdata);

    b64d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_char  (s_tdata),
        .is_final (s_tlast),
        .push     (push),
        .job      (push_job)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    b64d_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_job    (pop_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // A job is posted only for an accepted beat and never into a full queue.
    `B64D_ASSERT_IMP(a_push_has_room, push, accept && !q_full)
    // Every posted job carries at least one byte.
    `B64D_ASSERT_IMP(a_job_nonempty, push, push_job.count != 2'd0)
    // A skipped character without end of input posts nothing.
    `B64D_ASSERT_IMP(a_skip_no_job, accept && !s_tlast && !in_sx[6], !push)
    // A job taken from the queue shows up on the output in the next cycle.
    `B64D_ASSERT_NEXT(a_pop_shows, pop, m_tvalid)

endmodule

FILE: design/b64d_front.sv
// Front end: classify characters, collect sextets, post decode jobs.
module b64d_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    in_char,
    input  logic          is_final,
    output logic          push,
    output b64d_pkg::job_t job
);
    import b64d_pkg::*;

    logic [2:0][5:0] buf_reg, buf_next, buf_upd;
    logic [1:0]      cnt_reg, cnt_next, cnt_mid;
    logic [6:0]      sx;
    logic            full_grp;

    assign sx = char_to_sextet(in_char);

    always_comb
    begin
        buf_upd  = buf_reg;
        cnt_mid  = cnt_reg;
        full_grp = 1'b0;
        if (sx[6]) begin
            case (cnt_reg)
                2'd0: buf_upd[0] = sx[5:0];
                2'd1: buf_upd[1] = sx[5:0];
                2'd2: buf_upd[2] = sx[5:0];
                default: full_grp = 1'b1;
            endcase
            cnt_mid = full_grp ? 2'd0 : cnt_reg + 2'd1;
        end

        push      = 1'b0;
        job.bytes = decode_group(buf_reg[0], buf_reg[1], buf_reg[2], sx[5:0]);
        job.count = 2'd3;
        if (full_grp) begin
            push = accept;
        end else if (is_final && cnt_mid >= 2'd2) begin
            push      = accept;
            job.bytes = decode_group(buf_upd[0], buf_upd[1],
                                     (cnt_mid == 2'd3) ? buf_upd[2] : 6'd0, 6'd0);
            job.count = cnt_mid - 2'd1;
        end

        buf_next = accept ? buf_upd : buf_reg;
        cnt_next = accept ? (is_final ? 2'd0 : cnt_mid) : cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            buf_reg <= '0;
            cnt_reg <= 2'd0;
        end else begin
            buf_reg <= buf_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: design/b64d_queue.sv
// Job queue between the front end and the byte emitter.
module b64d_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b64d_pkg::job_t push_job,
    input  logic           pop,
    output b64d_pkg::job_t pop_job,
    output logic           full,
    output logic           empty
);
    import b64d_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t            mem [DEPTH];
    logic [AW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign pop_job = mem[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1);
        end
        if (pop) begin
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: design/b64d_back.sv
// Back end: take jobs from the queue and emit their bytes one beat at a time.
module b64d_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  b64d_pkg::job_t q_job,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast
);
    import b64d_pkg::*;

    job_t       job_reg, job_next;
    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       done;

    assign m_tvalid = valid_reg;
    assign m_tlast  = (idx_reg == job_reg.count - 2'd1);
    assign done     = valid_reg && m_tready && m_tlast;
    assign pop      = !q_empty && (!valid_reg || done);

    always_comb
    begin
        case (idx_reg)
            2'd0:    m_tdata = job_reg.bytes[0];
            2'd1:    m_tdata = job_reg.bytes[1];
            default: m_tdata = job_reg.bytes[2];
        endcase

        job_next   = job_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (pop) begin
            job_next   = q_job;
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end else if (done) begin
            valid_next = 1'b0;
        end else if (valid_reg && m_tready) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

FILE: tb/tb_base64_stream_decoder.sv
// Self-checking testbench for the streaming base64 decoder.
`timescale 1ns / 100ps

module tb_base64_stream_decoder;

    // One expected output beat: decoded byte plus its end-of-run mark.
    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } byte_beat_t;

    // Tracks the decoder's group state and the bytes it still owes.
    class base64_checker;
        logic [5:0]  held[3];
        int unsigned held_n;
        byte_beat_t  owed_bytes[$];
        int          errors;

        function new();
            held[0] = 6'd0;
            held[1] = 6'd0;
            held[2] = 6'd0;
            held_n  = 0;
            errors  = 0;
        endfunction

        // Return {is_sextet, value} for one character of the standard alphabet.
        function logic [6:0] sextet_of(logic [7:0] c);
            logic [7:0] v;
            v = 8'd0;
            if (c >= 8'h41 && c <= 8'h5a)          // 'A'..'Z'
            begin
                v = c - 8'h41;
                return {1'b1, v[5:0]};
            end
            if (c >= 8'h61 && c <= 8'h7a)          // 'a'..'z'
            begin
                v = c - 8'h61 + 8'd26;
                return {1'b1, v[5:0]};
            end
            if (c >= 8'h30 && c <= 8'h39)          // '0'..'9'
            begin
                v = c - 8'h30 + 8'd52;
                return {1'b1, v[5:0]};
            end
            if (c == 8'h2b)                        // '+'
                return {1'b1, 6'd62};
            if (c == 8'h2f)                        // '/'
                return {1'b1, 6'd63};
            return 7'd0;
        endfunction

        // Owe the first n bytes of a four-sextet group.
        function void owe_group(logic [5:0] s0, logic [5:0] s1, logic [5:0] s2,
                                logic [5:0] s3, int n);
            logic [7:0] b[3];
            byte_beat_t e;
            b[0] = {s0, s1[5:4]};
            b[1] = {s1[3:0], s2[5:2]};
            b[2] = {s2[1:0], s3};
            for (int k = 0; k < n; k++)
            begin
                e.data = b[k];
                e.last = (k == n - 1);
                owed_bytes.push_back(e);
            end
        endfunction

        // Advance the group state by one accepted input beat.
        function void note_char(logic [7:0] c, logic fin);
            logic [6:0] sx;
            int         n;
            sx = sextet_of(c);
            n  = 0;
            if (sx[6])
            begin
                if (held_n == 3)
                begin
                    owe_group(held[0], held[1], held[2], sx[5:0], 3);
                    n      = 3;
                    held_n = 0;
                end
                else
                begin
                    held[held_n] = sx[5:0];
                    held_n++;
                end
            end
            // End of input: flush a partial group of two or three sextets, drop one.
            if (fin)
            begin
                if (n == 0 && held_n >= 2)
                    owe_group(held[0], held[1], (held_n == 3) ? held[2] : 6'd0, 6'd0,
                              held_n - 1);
                held_n = 0;
            end
        endfunction

        // Compare one output beat with the oldest owed byte.
        function void check_byte(logic [7:0] data, logic last);
            byte_beat_t e;
            if (owed_bytes.size() == 0)
            begin
                $error("out_byte beat with nothing owed: got out_byte=%h run_last=%b",
                       data, last);
                errors++;
                return;
            end
            e = owed_bytes.pop_front();
            if (data !== e.data)
            begin
                $error("out_byte mismatch: expected %h, got %h", e.data, data);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("run_last mismatch: expected %b, got %b", e.last, last);
                errors++;
            end
        endfunction

        function int owed();
            return owed_bytes.size();
        endfunction
    endclass

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;   // [7:0] in_char
    logic       s_tlast  = 1'b0;   // is_final
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] out_byte
    logic       m_tlast;           // run_last

    base64_checker chk = new();

    // Idle rates in percent, set per phase by the stimulus.
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    // Beats that reach the decoding logic: alphabet characters or end-of-input marks.
    int decoded_beats  = 0;
    // Toggle to make the receiver hold off for a long stretch.
    bit hold_req       = 1'b0;

    localparam int HOLD_CYCLES = 60;

    base64_stream_decoder uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    // Sample both handshakes at the rising edge; note the input beat first.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                chk.note_char(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                chk.check_byte(m_tdata, m_tlast);
        end
    end

    // Receiver: stall at random, or hold off for HOLD_CYCLES when asked.
    initial
    begin : receiver
        int hold_left;
        bit hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one input beat, called just after a falling edge; return after the
    // falling edge that follows its acceptance, with tvalid still high.
    task automatic send_beat(input logic [7:0] c, input logic fin);
        logic [6:0] sx;
        sx = chk.sextet_of(c);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_tready);
        if (sx[6] || fin)
            decoded_beats++;
        @(negedge clk);
    endtask

    // Send a text, marking its last character as end of input if asked.
    task automatic send_text(input string txt, input bit final_on_last);
        for (int i = 0; i < txt.len(); i++)
            send_beat(txt[i], final_on_last && (i == txt.len() - 1));
    endtask

    function automatic logic [7:0] char_of(logic [5:0] v);
        if (v < 26)
            return 8'h41 + v;
        if (v < 52)
            return 8'h61 + v - 8'd26;
        if (v < 62)
            return 8'h30 + v - 8'd52;
        return (v == 6'd62) ? 8'h2b : 8'h2f;
    endfunction

    // Encode 1..8 random bytes, sometimes strip the padding, sprinkle noise in
    // and mark the last character as end of input.
    task automatic send_message();
        logic [7:0]  raw[$];
        logic [7:0]  txt[$];
        logic [23:0] w;
        int          len;
        int          i;
        len = $urandom_range(8, 1);
        for (i = 0; i < len; i++)
            raw.push_back(8'($urandom_range(255)));
        for (i = 0; i < len; i += 3)
        begin
            w = {raw[i], (i + 1 < len) ? raw[i + 1] : 8'd0, (i + 2 < len) ? raw[i + 2] : 8'd0};
            txt.push_back(char_of(w[23:18]));
            txt.push_back(char_of(w[17:12]));
            txt.push_back((i + 1 < len) ? char_of(w[11:6]) : 8'h3d);
            txt.push_back((i + 2 < len) ? char_of(w[5:0]) : 8'h3d);
        end
        if ($urandom_range(3) == 0)
            while (txt[txt.size() - 1] == 8'h3d)
                void'(txt.pop_back());
        for (i = 0; i < txt.size(); i++)
        begin
            if ($urandom_range(9) == 0)
                send_beat(8'($urandom_range(255)), 1'b0);
            send_beat(txt[i], i == txt.size() - 1);
        end
    endtask

    // Run one idling phase until about the given number of beats got decoded.
    task automatic run_phase(input int gap_pct, input int stall_pct, input int beats);
        int goal;
        int pick;
        int n;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        goal = decoded_beats + beats;
        while (decoded_beats < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_message();
            else if (pick < 85)
                send_beat(8'($urandom_range(255)), $urandom_range(7) == 0);
            else
            begin
                // Broken run: a few sextets, then end of input on any character.
                n = $urandom_range(5, 1);
                repeat (n)
                    send_beat(char_of(6'($urandom_range(63))), 1'b0);
                send_beat(8'($urandom_range(255)), 1'b1);
            end
        end
    endtask

    initial
    begin : stimulus
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: full group ended by its own last character.
        send_text("TWFu", 1'b1);
        // All-ones and high sextets, with noise bytes in the middle of the group.
        send_beat(8'h2f, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h2b, 1'b0);
        send_beat(8'hff, 1'b0);
        send_text("z9", 1'b0);
        // End of input with one sextet held: nothing comes out.
        send_text("Q", 1'b1);
        // End of input with nothing held.
        send_text("=", 1'b1);
        // Two sextets flushed by a character outside the alphabet.
        send_text("Za@", 1'b1);
        // Three sextets flushed by their last character.
        send_text("0AZ", 1'b1);
        // Characters at and around the alphabet's edges, all skipped.
        send_text("{*`:", 1'b0);
        send_text("AAAA", 1'b0);

        // One long receiver hold-off so the input backs up; phases of varied idling.
        s_tvalid <= 1'b0;
        @(posedge clk);
        hold_req = ~hold_req;
        @(negedge clk);
        run_phase(0, 0, 26);
        run_phase(51, 0, 26);
        run_phase(0, 51, 26);
        run_phase(15, 15, 26);
        s_tvalid <= 1'b0;

        // Drain what is still owed, then watch for stray beats.
        while (chk.owed() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (chk.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : watchdog
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/b64d_pkg.sv
design/b64d_front.sv
design/b64d_queue.sv
design/b64d_back.sv
design/base64_stream_decoder.sv
tb/tb_base64_stream_decoder.sv
